>>> rtl/core/ppp_pkg.sv
`default_nettype none
package ppp_pkg;

	localparam int DEF_SCREEN_WIDTH  = 640;
	localparam int DEF_SCREEN_HEIGHT = 480;

	localparam int FRAC_W  = 16;
	localparam int QUO_W   = 32;
	localparam int DIV_LAT = QUO_W + 2;
	localparam int PROD_W  = 66;
	localparam int N0_W    = 67;
	localparam int N1_W    = 99;
	localparam int N2_W    = 68;

	localparam logic [31:0]        MIN_NORM   = 32'd100;
	localparam logic [31:0]        WIN_LIMIT  = 32'd2048 << FRAC_W;
	localparam logic signed [31:0] DEPTH_NONE = -32'sd65536;

	typedef enum logic [2:0] {
		REG_ORIGIN_X = 3'd0,
		REG_ORIGIN_Y = 3'd1,
		REG_ORIGIN_Z = 3'd2,
		REG_EYE_X    = 3'd3,
		REG_EYE_Y    = 3'd4,
		REG_EYE_Z    = 3'd5,
		REG_VIEW_D   = 3'd6
	} ppp_reg_t;

	typedef struct packed {
		logic signed [31:0] ox, oy, oz;
		logic signed [31:0] ax, ay, az;
		logic [30:0]        vdist;
		logic [31:0]        hnorm, fnorm;
		logic [63:0]        hsq, fsq, fh;
		logic signed [63:0] ca, cb;
		logic               valid;
	} ppp_cam_t;

endpackage
`default_nettype wire

>>> rtl/core/ppp_cam.sv
`default_nettype none
module ppp_cam (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             cfg_valid,
	output logic                  cfg_ready,
	input  wire logic [2:0]       cfg_index,
	input  wire logic [31:0]      cfg_data,
	output ppp_pkg::ppp_cam_t     cam,
	output logic                  busy
);
	import ppp_pkg::*;

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_SQR  = 5'b00010,
		ST_SUM  = 5'b00100,
		ST_ROOT = 5'b01000,
		ST_PROD = 5'b10000
	} cam_state_t;

	cam_state_t state_q;

	logic signed [31:0] ox_q, oy_q, oz_q, ax_q, ay_q, az_q;
	logic [30:0] dist_q;
	logic [63:0] a2_q, b2_q, c2_q;
	logic [63:0] nh_q, nf_q, rad_h_q, rad_f_q;
	logic [33:0] rem_h_q, rem_f_q;
	logic [31:0] root_h_q, root_f_q;
	logic [4:0]  cnt_q;
	logic [63:0] hsq_q, fsq_q, fh_q;
	logic signed [63:0] ca_q, cb_q;
	logic valid_q;

	logic [31:0] ma, mb, mc;
	logic [35:0] sh_h, sh_f, tr_h, tr_f;
	logic take_h, take_f, wr;

	assign ma = ax_q[31] ? 32'(-ax_q) : 32'(ax_q);
	assign mb = ay_q[31] ? 32'(-ay_q) : 32'(ay_q);
	assign mc = az_q[31] ? 32'(-az_q) : 32'(az_q);

	assign sh_h   = {rem_h_q, rad_h_q[63:62]};
	assign sh_f   = {rem_f_q, rad_f_q[63:62]};
	assign tr_h   = {2'b00, root_h_q, 2'b01};
	assign tr_f   = {2'b00, root_f_q, 2'b01};
	assign take_h = sh_h >= tr_h;
	assign take_f = sh_f >= tr_f;

	assign cfg_ready = state_q == ST_IDLE;
	assign busy      = state_q != ST_IDLE;
	assign wr        = cfg_valid && cfg_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			ox_q     <= '0;
			oy_q     <= '0;
			oz_q     <= '0;
			ax_q     <= '0;
			ay_q     <= '0;
			az_q     <= '0;
			dist_q   <= '0;
			a2_q     <= '0;
			b2_q     <= '0;
			c2_q     <= '0;
			nh_q     <= '0;
			nf_q     <= '0;
			rad_h_q  <= '0;
			rad_f_q  <= '0;
			rem_h_q  <= '0;
			rem_f_q  <= '0;
			root_h_q <= '0;
			root_f_q <= '0;
			cnt_q    <= '0;
			hsq_q    <= '0;
			fsq_q    <= '0;
			fh_q     <= '0;
			ca_q     <= '0;
			cb_q     <= '0;
			valid_q  <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (wr) begin
						unique case (cfg_index)
							REG_ORIGIN_X: ox_q   <= cfg_data;
							REG_ORIGIN_Y: oy_q   <= cfg_data;
							REG_ORIGIN_Z: oz_q   <= cfg_data;
							REG_EYE_X:    ax_q   <= cfg_data;
							REG_EYE_Y:    ay_q   <= cfg_data;
							REG_EYE_Z:    az_q   <= cfg_data;
							REG_VIEW_D:   dist_q <= cfg_data[30:0];
							default:      ;
						endcase
						if (cfg_index <= REG_VIEW_D) begin
							state_q <= ST_SQR;
						end
					end
				end
				ST_SQR: begin
					a2_q    <= 64'(ma) * 64'(ma);
					b2_q    <= 64'(mb) * 64'(mb);
					c2_q    <= 64'(mc) * 64'(mc);
					state_q <= ST_SUM;
				end
				ST_SUM: begin
					nh_q     <= a2_q + b2_q;
					nf_q     <= a2_q + b2_q + c2_q;
					rad_h_q  <= a2_q + b2_q;
					rad_f_q  <= a2_q + b2_q + c2_q;
					rem_h_q  <= '0;
					rem_f_q  <= '0;
					root_h_q <= '0;
					root_f_q <= '0;
					cnt_q    <= '0;
					state_q  <= ST_ROOT;
				end
				ST_ROOT: begin
					rem_h_q  <= take_h ? 34'(sh_h - tr_h) : sh_h[33:0];
					rem_f_q  <= take_f ? 34'(sh_f - tr_f) : sh_f[33:0];
					root_h_q <= {root_h_q[30:0], take_h};
					root_f_q <= {root_f_q[30:0], take_f};
					rad_h_q  <= {rad_h_q[61:0], 2'b00};
					rad_f_q  <= {rad_f_q[61:0], 2'b00};
					cnt_q    <= cnt_q + 5'd1;
					if (cnt_q == 5'd31) begin
						state_q <= ST_PROD;
					end
				end
				ST_PROD: begin
					// root squared is radicand less remainder
					hsq_q   <= nh_q - 64'(rem_h_q);
					fsq_q   <= nf_q - 64'(rem_f_q);
					fh_q    <= 64'(root_f_q) * 64'(root_h_q);
					ca_q    <= 64'(az_q) * 64'(ax_q);
					cb_q    <= 64'(az_q) * 64'(ay_q);
					valid_q <= (root_f_q > MIN_NORM) && (root_h_q > MIN_NORM) &&
						(32'(dist_q) > MIN_NORM);
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_comb begin
		cam.ox    = ox_q;
		cam.oy    = oy_q;
		cam.oz    = oz_q;
		cam.ax    = ax_q;
		cam.ay    = ay_q;
		cam.az    = az_q;
		cam.vdist = dist_q;
		cam.hnorm = root_h_q;
		cam.fnorm = root_f_q;
		cam.hsq   = hsq_q;
		cam.fsq   = fsq_q;
		cam.fh    = fh_q;
		cam.ca    = ca_q;
		cam.cb    = cb_q;
		cam.valid = valid_q;
	end

endmodule
`default_nettype wire

>>> rtl/core/ppp_xform.sv
`default_nettype none
module ppp_xform (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          en,
	input  wire logic                          in_valid,
	input  wire logic signed [31:0]            point_x,
	input  wire logic signed [31:0]            point_y,
	input  wire logic signed [31:0]            point_z,
	input  wire ppp_pkg::ppp_cam_t             cam,
	output logic                               out_valid,
	output logic signed [ppp_pkg::N0_W-1:0]    num0,
	output logic signed [ppp_pkg::N1_W-1:0]    num1,
	output logic signed [ppp_pkg::N2_W-1:0]    num2
);
	import ppp_pkg::*;

	logic v_s1, v_s2, v_s3, v_s4;
	logic signed [32:0] xw_s1, yw_s1, zw_s1;

	logic signed [PROD_W-1:0] axw_s2, byw_s2, bxw_s2, ayw_s2, czw_s2;
	logic signed [PROD_W-1:0] zvh_s2, zvl_s2, xch_s2, xcl_s2, ych_s2, ycl_s2;

	logic signed [N0_W-1:0] n0_s3, n0_s4;
	logic signed [N2_W-1:0] n2a_s3, czw_s3, n2_s4;
	logic signed [N1_W-1:0] zv_s3, xc_s3, yc_s3, n1_s4;

	logic signed [32:0] hsq_hi, hsq_lo, ca_hi, ca_lo, cb_hi, cb_lo;

	assign hsq_hi = $signed({1'b0, cam.hsq[63:32]});
	assign hsq_lo = $signed({1'b0, cam.hsq[31:0]});
	assign ca_hi  = 33'($signed(cam.ca[63:32]));
	assign ca_lo  = $signed({1'b0, cam.ca[31:0]});
	assign cb_hi  = 33'($signed(cam.cb[63:32]));
	assign cb_lo  = $signed({1'b0, cam.cb[31:0]});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			xw_s1 <= 33'(point_x) - 33'(cam.ox);
			yw_s1 <= 33'(point_y) - 33'(cam.oy);
			zw_s1 <= 33'(point_z) - 33'(cam.oz);

			axw_s2 <= PROD_W'(xw_s1) * PROD_W'(cam.ax);
			byw_s2 <= PROD_W'(yw_s1) * PROD_W'(cam.ay);
			bxw_s2 <= PROD_W'(xw_s1) * PROD_W'(cam.ay);
			ayw_s2 <= PROD_W'(yw_s1) * PROD_W'(cam.ax);
			czw_s2 <= PROD_W'(zw_s1) * PROD_W'(cam.az);
			zvh_s2 <= PROD_W'(zw_s1) * PROD_W'(hsq_hi);
			zvl_s2 <= PROD_W'(zw_s1) * PROD_W'(hsq_lo);
			xch_s2 <= PROD_W'(xw_s1) * PROD_W'(ca_hi);
			xcl_s2 <= PROD_W'(xw_s1) * PROD_W'(ca_lo);
			ych_s2 <= PROD_W'(yw_s1) * PROD_W'(cb_hi);
			ycl_s2 <= PROD_W'(yw_s1) * PROD_W'(cb_lo);

			n0_s3  <= N0_W'(ayw_s2) - N0_W'(bxw_s2);
			n2a_s3 <= N2_W'($signed({1'b0, cam.fsq})) - N2_W'(axw_s2) - N2_W'(byw_s2);
			czw_s3 <= N2_W'(czw_s2);
			zv_s3  <= (N1_W'(zvh_s2) <<< 32) + N1_W'(zvl_s2);
			xc_s3  <= (N1_W'(xch_s2) <<< 32) + N1_W'(xcl_s2);
			yc_s3  <= (N1_W'(ych_s2) <<< 32) + N1_W'(ycl_s2);

			n0_s4 <= n0_s3;
			n1_s4 <= zv_s3 - xc_s3 - yc_s3;
			n2_s4 <= n2a_s3 - czw_s3;
		end
	end

	assign out_valid = v_s4;
	assign num0      = n0_s4;
	assign num1      = n1_s4;
	assign num2      = n2_s4;

endmodule
`default_nettype wire

>>> rtl/core/ppp_div.sv
`default_nettype none
module ppp_div #(
	parameter int NUM_W = 64,
	parameter int DEN_W = 32
) (
	input  wire logic                    clk,
	input  wire logic                    en,
	input  wire logic signed [NUM_W-1:0] num,
	input  wire logic [DEN_W-1:0]        den,
	output logic                         neg,
	output logic                         ovf,
	output logic [ppp_pkg::QUO_W-1:0]    quo
);
	import ppp_pkg::*;

	localparam int W = (NUM_W > DEN_W + QUO_W + 1) ? NUM_W : DEN_W + QUO_W + 1;

	logic             neg_sa;
	logic [NUM_W-1:0] mag_sa;
	logic [DEN_W-1:0] den_sa;

	logic [W-1:0]     rem_s [0:QUO_W-1];
	logic [DEN_W-1:0] den_s [0:QUO_W-1];
	logic             neg_s [0:QUO_W];
	logic             ovf_s [0:QUO_W];
	logic [QUO_W-1:0] q_s   [0:QUO_W];

	always_ff @(posedge clk) begin
		if (en) begin
			neg_sa   <= num[NUM_W-1];
			mag_sa   <= num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
			den_sa   <= den;
			rem_s[0] <= W'(mag_sa);
			den_s[0] <= den_sa;
			neg_s[0] <= neg_sa;
			ovf_s[0] <= W'(mag_sa) >= (W'(den_sa) << QUO_W);
			q_s[0]   <= '0;
		end
	end

	for (genvar k = 0; k < QUO_W; k++) begin : g_step
		logic [W-1:0] dsh;
		logic         take;

		assign dsh  = W'(den_s[k]) << (QUO_W - 1 - k);
		assign take = rem_s[k] >= dsh;

		always_ff @(posedge clk) begin
			if (en) begin
				neg_s[k+1] <= neg_s[k];
				ovf_s[k+1] <= ovf_s[k];
				q_s[k+1]   <= {q_s[k][QUO_W-2:0], take};
			end
		end

		if (k < QUO_W - 1) begin : g_rem
			always_ff @(posedge clk) begin
				if (en) begin
					rem_s[k+1] <= take ? rem_s[k] - dsh : rem_s[k];
					den_s[k+1] <= den_s[k];
				end
			end
		end
	end

	assign neg = neg_s[QUO_W];
	assign ovf = ovf_s[QUO_W];
	assign quo = q_s[QUO_W];

endmodule
`default_nettype wire

>>> rtl/core/perspective_point_projection.sv
`default_nettype none
// Perspective projection of one Q16.16 world point per word onto a screen
// centred at (SCREEN_WIDTH/2, SCREEN_HEIGHT/2). A new point is taken every
// cycle while the output side keeps up; each result passes the transform,
// then the two 34-stage restoring dividers in series (eye space, then screen
// scale), then the output stages. Each register write starts a recompute
// of the camera norms (two digit-serial square roots, one bit a cycle),
// during which cfg_ready and s_tready are low.
// Invalid camera or a point not in front gives x = y = 0 and depth -1.0.
module perspective_point_projection #(
	parameter int SCREEN_WIDTH  = ppp_pkg::DEF_SCREEN_WIDTH,
	parameter int SCREEN_HEIGHT = ppp_pkg::DEF_SCREEN_HEIGHT
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_tvalid,
	output logic              s_tready,
	input  wire logic [95:0]  s_tdata,   // point_x, point_y, point_z
	output logic              m_tvalid,
	input  wire logic         m_tready,
	output logic [103:0]      m_tdata,   // screen_x, screen_y, eye_depth, visible, pad
	input  wire logic         cfg_valid,
	output logic              cfg_ready,
	input  wire logic [2:0]   cfg_index,
	input  wire logic [31:0]  cfg_data
);
	import ppp_pkg::*;

	localparam logic signed [34:0] CENTRE_X = 35'((SCREEN_WIDTH / 2) * 65536);
	localparam logic signed [34:0] CENTRE_Y = 35'((SCREEN_HEIGHT / 2) * 65536);

	function automatic logic signed [31:0] sat32(input logic signed [34:0] v);
		logic signed [31:0] r;
		if (v > 35'sd2147483647) r = 32'sh7fffffff;
		else if (v < -35'sd2147483648) r = 32'sh80000000;
		else r = 32'(v);
		return r;
	endfunction

	function automatic logic signed [31:0] sat_quo(input logic n, input logic o,
			input logic [31:0] q);
		logic signed [31:0] r;
		if (!n) r = (o || q[31]) ? 32'sh7fffffff : $signed(q);
		else r = (o || q > 32'h80000000) ? 32'sh80000000 : $signed(32'(-q));
		return r;
	endfunction

	ppp_cam_t cam;
	logic busy, en;

	logic v_x;
	logic signed [N0_W-1:0] num0;
	logic signed [N1_W-1:0] num1;
	logic signed [N2_W-1:0] num2;

	logic d0_neg, d0_ovf, d1_neg, d1_ovf, d2_neg, d2_ovf;
	logic [QUO_W-1:0] d0_q, d1_q, d2_q;
	logic dx_neg, dx_ovf, dy_neg, dy_ovf;
	logic [QUO_W-1:0] dx_q, dy_q;

	logic d1_vld_s [0:DIV_LAT-1];
	logic d2_vld_s [0:DIV_LAT-1];
	logic signed [31:0] d2_e2_s [0:DIV_LAT-1];

	logic v_s5, v_s6;
	logic signed [31:0] e0_s5, e1_s5, e2_s5, e2_s6;
	logic signed [63:0] mx_s6, my_s6;

	logic [96:0] buf_q [0:1];
	logic [1:0]  cnt_q;
	logic        rd_q, wr_q;
	logic        push, pop;

	logic signed [33:0] xsv, ysv;
	logic signed [31:0] sx, sy, depth;
	logic ok, vis;
	logic [31:0] e2f;

	ppp_cam u_cam (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cam       (cam),
		.busy      (busy)
	);

	assign en       = cnt_q != 2'd2;
	assign s_tready = en && !busy;

	ppp_xform u_xform (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (s_tvalid && s_tready),
		.point_x   (s_tdata[31:0]),
		.point_y   (s_tdata[63:32]),
		.point_z   (s_tdata[95:64]),
		.cam       (cam),
		.out_valid (v_x),
		.num0      (num0),
		.num1      (num1),
		.num2      (num2)
	);

	ppp_div #(.NUM_W(N0_W), .DEN_W(32)) u_div_e0 (
		.clk (clk), .en (en), .num (num0), .den (cam.hnorm),
		.neg (d0_neg), .ovf (d0_ovf), .quo (d0_q)
	);

	ppp_div #(.NUM_W(N1_W), .DEN_W(64)) u_div_e1 (
		.clk (clk), .en (en), .num (num1), .den (cam.fh),
		.neg (d1_neg), .ovf (d1_ovf), .quo (d1_q)
	);

	ppp_div #(.NUM_W(N2_W), .DEN_W(32)) u_div_e2 (
		.clk (clk), .en (en), .num (num2), .den (cam.fnorm),
		.neg (d2_neg), .ovf (d2_ovf), .quo (d2_q)
	);

	ppp_div #(.NUM_W(64), .DEN_W(31)) u_div_x (
		.clk (clk), .en (en), .num (mx_s6), .den (e2_s6[30:0]),
		.neg (dx_neg), .ovf (dx_ovf), .quo (dx_q)
	);

	ppp_div #(.NUM_W(64), .DEN_W(31)) u_div_y (
		.clk (clk), .en (en), .num (my_s6), .den (e2_s6[30:0]),
		.neg (dy_neg), .ovf (dy_ovf), .quo (dy_q)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < DIV_LAT; i++) begin
				d1_vld_s[i] <= 1'b0;
				d2_vld_s[i] <= 1'b0;
			end
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else if (en) begin
			d1_vld_s[0] <= v_x;
			d2_vld_s[0] <= v_s6;
			for (int i = 1; i < DIV_LAT; i++) begin
				d1_vld_s[i] <= d1_vld_s[i-1];
				d2_vld_s[i] <= d2_vld_s[i-1];
			end
			v_s5 <= d1_vld_s[DIV_LAT-1];
			v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			e0_s5 <= sat_quo(d0_neg, d0_ovf, d0_q);
			e1_s5 <= sat_quo(d1_neg, d1_ovf, d1_q);
			e2_s5 <= sat_quo(d2_neg, d2_ovf, d2_q);
			mx_s6 <= 64'(e0_s5) * 64'($signed({1'b0, cam.vdist}));
			my_s6 <= 64'(e1_s5) * 64'($signed({1'b0, cam.vdist}));
			e2_s6 <= e2_s5;
			d2_e2_s[0] <= e2_s6;
			for (int i = 1; i < DIV_LAT; i++) begin
				d2_e2_s[i] <= d2_e2_s[i-1];
			end
		end
	end

	// final stage: centre offset, saturation and window test
	assign e2f = d2_e2_s[DIV_LAT-1];
	assign xsv = dx_neg ? -$signed({2'b00, dx_q}) : $signed({2'b00, dx_q});
	assign ysv = dy_neg ? -$signed({2'b00, dy_q}) : $signed({2'b00, dy_q});
	assign ok  = cam.valid && ($signed(e2f) > 32'sd0);

	always_comb begin
		sx    = '0;
		sy    = '0;
		depth = DEPTH_NONE;
		vis   = 1'b0;
		if (ok) begin
			sx    = dx_ovf ? (dx_neg ? 32'sh80000000 : 32'sh7fffffff)
				: sat32(35'(xsv) + CENTRE_X);
			sy    = dy_ovf ? (dy_neg ? 32'sh80000000 : 32'sh7fffffff)
				: sat32(35'(ysv) + CENTRE_Y);
			depth = e2f;
			vis   = !dx_ovf && !dy_ovf && (dx_q <= WIN_LIMIT) && (dy_q <= WIN_LIMIT);
		end
	end

	assign push = en && d2_vld_s[DIV_LAT-1];
	assign pop  = m_tvalid && m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			rd_q  <= 1'b0;
			wr_q  <= 1'b0;
		end else begin
			if (push) wr_q <= !wr_q;
			if (pop) rd_q <= !rd_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			buf_q[wr_q] <= {vis, depth, sy, sx};
		end
	end

	assign m_tvalid = cnt_q != 2'd0;
	assign m_tdata  = {7'b0, buf_q[rd_q]};

endmodule
`default_nettype wire
